@@ hw/rtl/opi_pkg.sv @@
// Shared types and constants for the odometry pose integrator.
// Holds the sequencer state type, the CORDIC gain and the arctangent table.
// No dependencies.
package opi_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_TAB_LEN   = 24;
	localparam int GUARD_BITS       = 8;
	localparam int GAIN_SHIFT       = 30 - GUARD_BITS;

	// CORDIC gain compensation, Q2.30
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// Working widths of the rotation datapath
	localparam int VEC_W  = 33;  // displacement or pose, exact
	localparam int ROT_W  = 44;  // scaled vector with guard bits and growth
	localparam int ANG_W  = 34;  // angle accumulator, pi = 2^31
	localparam int RND_W  = ROT_W - GUARD_BITS;
	localparam int SUM_W  = 37;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_ITER,
		ST_ROUND,
		ST_FINISH
	} state_t;

	// atan(2^-i) with pi = 2^31
	localparam logic [31:0] ATAN_TAB [CORDIC_TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	function automatic logic [31:0] atan_at(input logic [4:0] idx);
		return ATAN_TAB[idx];
	endfunction

endpackage

@@ hw/rtl/opi_channels.sv @@
// Handshake channels of the odometry pose integrator.
// Input item channel and result channel, valid/ready with payload.
// No dependencies.
interface opi_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] angle;

	modport source (output valid, kind, pos_x, pos_y, angle, input ready);
	modport sink   (input valid, kind, pos_x, pos_y, angle, output ready);
endinterface

interface opi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] map_pos_x;
	logic signed [31:0] map_pos_y;
	logic signed [15:0] map_heading;
	logic               saturated;

	modport source (output valid, map_pos_x, map_pos_y, map_heading, saturated,
		input ready);
	modport sink   (input valid, map_pos_x, map_pos_y, map_heading, saturated,
		output ready);
endinterface

@@ hw/rtl/odometry_pose_integrator_unit.sv @@
// Odometry pose integrator: SE(2) dead reckoning with rigid pose correction.
// Depends on opi_pkg and the channel interfaces in opi_channels.sv.
//
//  channel  | role | carries
//  ---------+------+-------------------------------------------------
//  item     | sink | kind, pos_x, pos_y, angle
//  result   | src  | map_pos_x, map_pos_y, map_heading, saturated
//
// The block takes a new item only from idle, after the last one is through:
// the gain multiply on one shared 17x32 multiplier, a fold, one CORDIC step
// per cycle on a shared add/shift unit, rounding, a final sum and clamp,
// and the return to idle.
// arst_n clears both poses to zero and empties the result register.
// A result waits in the output register; a stalled result only holds the
// final cycle, the input is taken again as soon as the result is registered.
module odometry_pose_integrator_unit
	import opi_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	opi_in_if.sink      item,
	opi_out_if.source   result
);

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	state_t state_q, state_d;

	logic [1:0]    mcnt_q;
	logic [IW-1:0] icnt_q;

	// persistent pose state
	logic signed [31:0] pose_x_q, pose_y_q, last_x_q, last_y_q;
	logic signed [15:0] pose_h_q, last_h_q;

	// working registers
	logic signed [VEC_W-1:0] vx_q, vy_q;
	logic signed [15:0]      ang_q;
	logic signed [31:0]      base_x_q, base_y_q;
	logic signed [63:0]      acc_q;
	logic signed [ROT_W-1:0] cx_q, cy_q;
	logic signed [ANG_W-1:0] z_q;
	logic signed [RND_W-1:0] rx_q, ry_q;

	// result register
	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic signed [15:0] out_h_q;
	logic               out_sat_q;

	logic in_take, out_load;

	// shared multiplier
	logic signed [16:0] mul_a;
	logic signed [48:0] mul_p;
	logic signed [63:0] mul_sum;
	logic signed [63:0] mul_scaled;

	// shared add/shift unit
	logic signed [ROT_W-1:0] dx, dy;
	logic signed [ANG_W-1:0] atan_v;
	logic                    fold;
	logic signed [15:0]      ang_fold;
	logic signed [ROT_W-1:0] rnd_x, rnd_y;

	// final sum and clamp
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [31:0]      clp_x, clp_y;
	logic                    ovf_x, ovf_y;

	assign item.ready = (state_q == ST_IDLE);
	assign in_take    = item.valid && item.ready;
	assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || result.ready);

	always_comb begin
		case (mcnt_q)
			2'd0:    mul_a = signed'({1'b0, vx_q[15:0]});
			2'd1:    mul_a = vx_q[32:16];
			2'd2:    mul_a = signed'({1'b0, vy_q[15:0]});
			default: mul_a = vy_q[32:16];
		endcase
	end

	assign mul_p      = mul_a * GAIN_Q30;
	assign mul_sum    = acc_q + (64'(mul_p) <<< 16);
	assign mul_scaled = mul_sum >>> GAIN_SHIFT;

	assign dx     = cy_q >>> icnt_q;
	assign dy     = cx_q >>> icnt_q;
	assign atan_v = signed'(ANG_W'(atan_at(5'(icnt_q))));

	assign fold     = (ang_q > 16'sd16384) || (ang_q < -16'sd16384);
	assign ang_fold = ang_q + 16'sh8000;

	assign rnd_x = cx_q + ROT_W'(128);
	assign rnd_y = cy_q + ROT_W'(128);

	assign sum_x = SUM_W'(base_x_q) + SUM_W'(rx_q);
	assign sum_y = SUM_W'(base_y_q) + SUM_W'(ry_q);
	assign ovf_x = (sum_x[SUM_W-1:31] != '0) && (sum_x[SUM_W-1:31] != '1);
	assign ovf_y = (sum_y[SUM_W-1:31] != '0) && (sum_y[SUM_W-1:31] != '1);

	always_comb begin
		clp_x = sum_x[31:0];
		clp_y = sum_y[31:0];
		if (ovf_x) begin
			clp_x = sum_x[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		if (ovf_y) begin
			clp_y = sum_y[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_take) state_d = ST_MUL;
			ST_MUL:    if (mcnt_q == 2'd3) state_d = ST_FOLD;
			ST_FOLD:   state_d = ST_ITER;
			ST_ITER:   if (icnt_q == IW'(CORDIC_STEPS - 1)) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_FINISH;
			ST_FINISH: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// counters, pose state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q      <= '0;
			icnt_q      <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_h_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				mcnt_q <= '0;
				if (item.kind) begin
					pose_h_q <= pose_h_q + item.angle;
				end else begin
					pose_h_q <= pose_h_q + item.angle - last_h_q;
					last_x_q <= item.pos_x;
					last_y_q <= item.pos_y;
					last_h_q <= item.angle;
				end
			end
			if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q + 2'd1;
			end
			if (state_q == ST_FOLD) begin
				icnt_q <= '0;
			end
			if (state_q == ST_ITER) begin
				icnt_q <= IW'(icnt_q + 1'b1);
			end
			if (out_load) begin
				pose_x_q    <= clp_x;
				pose_y_q    <= clp_y;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			if (item.kind) begin
				vx_q     <= VEC_W'(pose_x_q);
				vy_q     <= VEC_W'(pose_y_q);
				ang_q    <= item.angle;
				base_x_q <= item.pos_x;
				base_y_q <= item.pos_y;
			end else begin
				vx_q     <= VEC_W'(item.pos_x) - VEC_W'(last_x_q);
				vy_q     <= VEC_W'(item.pos_y) - VEC_W'(last_y_q);
				ang_q    <= pose_h_q - last_h_q;
				base_x_q <= pose_x_q;
				base_y_q <= pose_y_q;
			end
		end
		case (state_q)
			ST_MUL: begin
				case (mcnt_q)
					2'd0:    acc_q <= 64'(mul_p);
					2'd1:    cx_q  <= mul_scaled[ROT_W-1:0];
					2'd2:    acc_q <= 64'(mul_p);
					default: cy_q  <= mul_scaled[ROT_W-1:0];
				endcase
			end
			ST_FOLD: begin
				// bring the angle into +-pi/2 by a half turn
				if (fold) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
					z_q  <= {{2{ang_fold[15]}}, ang_fold, 16'h0000};
				end else begin
					z_q  <= {{2{ang_q[15]}}, ang_q, 16'h0000};
				end
			end
			ST_ITER: begin
				if (!z_q[ANG_W-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - atan_v;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + atan_v;
				end
			end
			ST_ROUND: begin
				rx_q <= rnd_x[ROT_W-1:GUARD_BITS];
				ry_q <= rnd_y[ROT_W-1:GUARD_BITS];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_x_q   <= clp_x;
			out_y_q   <= clp_y;
			out_h_q   <= pose_h_q;
			out_sat_q <= ovf_x || ovf_y;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.map_pos_x   = out_x_q;
	assign result.map_pos_y   = out_y_q;
	assign result.map_heading = out_h_q;
	assign result.saturated   = out_sat_q;

endmodule

@@ test/opi_pose_checker.sv @@
// Scoreboard for the odometry pose integrator: predicts each map pose and
// compares it with the result channel. Also holds the item kind codes.
// Depends on the channel interfaces in opi_channels.sv.
`timescale 1ns / 1ps

package opi_tb_pkg;
	typedef enum logic {
		KIND_ODOM = 1'b0,
		KIND_CORR = 1'b1
	} item_kind_t;
endpackage

module opi_pose_checker
	import opi_tb_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	opi_in_if           item,
	opi_out_if          result,
	output int unsigned mismatches,
	output int unsigned pending
);

	localparam int     MAX_REPORTS = 10;
	localparam int     ROT_GUARD   = 8;
	localparam longint ROT_GAIN    = 652032874;
	localparam longint POS_MAX     = 64'sd2147483647;
	localparam longint POS_MIN     = -64'sd2147483648;
	localparam int     ROT_ITERS   = (STEPS > 24) ? 24 : ((STEPS < 0) ? 0 : STEPS);

	// atan(2^-i), half turn = 2^31
	localparam longint ATAN_STEP [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] hdg;
		logic               sat;
	} pose_rec_t;

	pose_rec_t expected_poses [$];

	logic signed [31:0] odom_x, odom_y, map_x, map_y;
	logic signed [15:0] odom_hdg, map_hdg;

	function automatic void cordic_rotate(input longint vx, input longint vy,
		input longint ang, output longint ox, output longint oy);
		longint cx, cy, z, dx, dy;
		logic signed [15:0] folded;
		cx = (vx * ROT_GAIN) >>> (30 - ROT_GUARD);
		cy = (vy * ROT_GAIN) >>> (30 - ROT_GUARD);
		// beyond a quarter turn: negate the vector and turn the angle by pi
		if (ang > 16384 || ang < -16384) begin
			cx = -cx;
			cy = -cy;
			folded = 16'(ang + 32768);
			ang = longint'(folded);
		end
		z = ang * 65536;
		for (int i = 0; i < ROT_ITERS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				z = z - ATAN_STEP[i];
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				z = z + ATAN_STEP[i];
			end
		end
		ox = (cx + (longint'(1) <<< (ROT_GUARD - 1))) >>> ROT_GUARD;
		oy = (cy + (longint'(1) <<< (ROT_GUARD - 1))) >>> ROT_GUARD;
	endfunction

	function automatic logic signed [31:0] clamp_pos(input longint v, inout bit sat);
		if (v > POS_MAX) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < POS_MIN) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return 32'(v);
	endfunction

	function automatic pose_rec_t advance_pose(input item_kind_t kind,
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [15:0] ang);
		longint rx, ry, sx, sy;
		logic signed [15:0] turn;
		bit sat;
		pose_rec_t res;
		sat = 1'b0;
		if (kind == KIND_ODOM) begin
			// one rotation by the map-to-odometry heading offset covers both frames
			turn = map_hdg - odom_hdg;
			cordic_rotate(longint'(px) - longint'(odom_x), longint'(py) - longint'(odom_y),
				longint'(turn), rx, ry);
			sx = longint'(map_x) + rx;
			sy = longint'(map_y) + ry;
			map_hdg = map_hdg + (ang - odom_hdg);
			odom_x = px;
			odom_y = py;
			odom_hdg = ang;
		end else begin
			cordic_rotate(longint'(map_x), longint'(map_y), longint'(ang), rx, ry);
			sx = rx + longint'(px);
			sy = ry + longint'(py);
			map_hdg = map_hdg + ang;
		end
		map_x = clamp_pos(sx, sat);
		map_y = clamp_pos(sy, sat);
		res.x = map_x;
		res.y = map_y;
		res.hdg = map_hdg;
		res.sat = sat;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pose_rec_t got, want;
		if (!arst_n) begin
			odom_x = '0;
			odom_y = '0;
			odom_hdg = '0;
			map_x = '0;
			map_y = '0;
			map_hdg = '0;
			expected_poses.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// results first: a transfer in this cycle cannot be answered yet
			if (result.valid && result.ready) begin
				got = '{result.map_pos_x, result.map_pos_y, result.map_heading,
					result.saturated};
				if (expected_poses.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result x=%0d y=%0d hdg=%0d sat=%0b",
							$realtime, got.x, got.y, got.hdg, got.sat);
				end else begin
					want = expected_poses.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.hdg !== want.hdg ||
						got.sat !== want.sat) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: pose mismatch exp x=%0d y=%0d hdg=%0d sat=%0b,",
								" got x=%0d y=%0d hdg=%0d sat=%0b"},
								$realtime, want.x, want.y, want.hdg, want.sat,
								got.x, got.y, got.hdg, got.sat);
					end
				end
			end
			if (item.valid && item.ready)
				expected_poses.insert(expected_poses.size(),
					advance_pose(item_kind_t'(item.kind),
					item.pos_x, item.pos_y, item.angle));
			pending = expected_poses.size();
		end
	end

endmodule

@@ test/odometry_pose_integrator_unit_tb.sv @@
// Top of the odometry pose integrator testbench: clock, reset, stimulus
// and verdict. Depends on opi_pkg, opi_channels.sv and opi_pose_checker.sv.
`timescale 1ns / 1ps

module odometry_pose_integrator_unit_tb;
	import opi_tb_pkg::*;

	localparam int ROT_STEPS    = 16;
	localparam int PHASE_ITEMS  = 200;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned send_idle;
	int unsigned recv_idle;

	// odometry pose last sent, so random odometry moves in small steps
	logic signed [31:0] odom_x, odom_y;
	logic signed [15:0] odom_hdg;

	opi_in_if  item_ch ();
	opi_out_if result_ch ();

	odometry_pose_integrator_unit #(
		.CORDIC_STEPS(ROT_STEPS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	opi_pose_checker #(
		.STEPS(ROT_STEPS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);

	task automatic send_item(input item_kind_t kind, input logic signed [31:0] px,
		input logic signed [31:0] py, input logic signed [15:0] ang);
		while ($urandom_range(0, 99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.pos_x <= px;
		item_ch.pos_y <= py;
		item_ch.angle <= ang;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (kind == KIND_ODOM) begin
			odom_x = px;
			odom_y = py;
			odom_hdg = ang;
		end
	endtask

	task automatic send_random_item();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 72)
			send_item(KIND_ODOM,
				odom_x + int'($urandom_range(0, 1048576)) - 524288,
				odom_y + int'($urandom_range(0, 1048576)) - 524288,
				odom_hdg + 16'($urandom_range(0, 4095)) - 16'sd2048);
		else if (pick < 88)
			send_item(KIND_CORR,
				int'($urandom_range(0, 524288)) - 262144,
				int'($urandom_range(0, 524288)) - 262144,
				16'($urandom));
		else if (pick < 94)
			send_item(KIND_ODOM, 32'($urandom), 32'($urandom), 16'($urandom));
		else
			send_item(KIND_CORR, 32'($urandom), 32'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_ODOM;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.angle = '0;
		result_ch.ready = 1'b0;
		send_idle = 16;
		recv_idle = 68;
		odom_x = '0;
		odom_y = '0;
		odom_hdg = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: quarter-turn edges, fold, half turn, wrap, saturation
		send_item(KIND_ODOM, 32'sd0, 32'sd0, 16'sd0);
		send_item(KIND_ODOM, 32'sh0001_0000, 32'sh0002_0000, 16'sd8192);
		send_item(KIND_ODOM, 32'sh0001_0000, 32'sh0002_0000, 16'sd8192);
		send_item(KIND_CORR, 32'sd0, 32'sd0, 16'sd16384);
		send_item(KIND_CORR, 32'sd0, 32'sd0, -16'sd16384);
		send_item(KIND_CORR, 32'sd0, 32'sd0, 16'sd16385);
		send_item(KIND_CORR, 32'sd0, 32'sd0, -16'sd16385);
		send_item(KIND_CORR, 32'sd0, 32'sd0, 16'sh8000);
		send_item(KIND_CORR, 32'sd0, 32'sd0, 16'sh7FFF);
		send_item(KIND_ODOM, 32'sh0005_0000, -32'sh0003_0000, -16'sd20000);
		send_item(KIND_ODOM, 32'sh0004_8000, -32'sh0002_0000, 16'sd30000);
		send_item(KIND_ODOM, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF);
		send_item(KIND_ODOM, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000);
		send_item(KIND_CORR, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0);
		send_item(KIND_CORR, 32'sh8000_0000, 32'sh8000_0000, 16'sd0);
		send_item(KIND_CORR, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000);
		send_item(KIND_CORR, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd16384);
		send_item(KIND_ODOM, 32'sd0, 32'sd0, 16'sd0);
		send_item(KIND_ODOM, -32'sd1, 32'sd1, -16'sd1);
		send_item(KIND_CORR, 32'sd1, -32'sd1, 16'sd1);

		repeat (PHASE_ITEMS) send_random_item();

		// hold off until the block has drained, then swap the idling
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		send_idle = 68;
		recv_idle = 16;
		repeat (PHASE_ITEMS) send_random_item();

		send_idle = 0;
		recv_idle = 0;
		repeat (PHASE_ITEMS) send_random_item();

		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ odometry_pose_integrator_unit.f @@
hw/rtl/opi_pkg.sv
hw/rtl/opi_channels.sv
hw/rtl/odometry_pose_integrator_unit.sv
test/opi_pose_checker.sv
test/odometry_pose_integrator_unit_tb.sv
